### src/e2q_pkg.sv
`timescale 1ns / 1ps
package e2q_pkg;
   localparam int ANGLE_BITS     = 16;
   localparam int COMPONENT_BITS = 16;
   localparam int CORDIC_STAGES  = 14;
   localparam int TABLE_LEN      = 30;
   localparam int CW             = 34;

   localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;

   localparam logic signed [CW-1:0] ATAN_Q30 [TABLE_LEN] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
      34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
      34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536,
      34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
      34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64,
      34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2
   };

   function automatic int run_stages(input int stages);
      return (stages < TABLE_LEN) ? stages : TABLE_LEN;
   endfunction

   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [63:0] prod;
      logic signed [63:0] sum;
      prod = a * b;
      sum  = prod + 64'sd536870912;
      return sum[61:30];
   endfunction
endpackage

### src/e2q_cordic.sv
`timescale 1ns / 1ps
module e2q_cordic #(
   parameter int ANGLE_BITS    = e2q_pkg::ANGLE_BITS,
   parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES
) (
   input  logic                                              clock,
   input  logic [e2q_pkg::run_stages(CORDIC_STAGES):0]       adv,
   input  logic signed [ANGLE_BITS-1:0]                      angle,
   output logic signed [31:0]                                cos_q30,
   output logic signed [31:0]                                sin_q30
);
   localparam int NRUN = e2q_pkg::run_stages(CORDIC_STAGES);
   localparam int SH   = 32 - ANGLE_BITS;
   localparam int CW   = e2q_pkg::CW;

   logic signed [CW-1:0] x_ff [0:NRUN];
   logic signed [CW-1:0] y_ff [0:NRUN];
   logic signed [CW-1:0] z_ff [0:NRUN];
   logic                 neg_ff [0:NRUN];

   logic signed [CW-1:0] h;
   logic signed [CW-1:0] z_in;
   logic                 neg_in;

   always_comb begin
      h = CW'(angle) <<< SH;
      if (h > e2q_pkg::HALF_PI_Q30) begin
         z_in   = e2q_pkg::PI_Q30 - h;
         neg_in = 1'b1;
      end else if (h < -e2q_pkg::HALF_PI_Q30) begin
         z_in   = -e2q_pkg::PI_Q30 - h;
         neg_in = 1'b1;
      end else begin
         z_in   = h;
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff[0]   <= e2q_pkg::GAIN_Q30;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar k = 1; k <= NRUN; k++) begin : g_iter
      logic signed [CW-1:0] xs, ys;
      assign xs = x_ff[k-1] >>> (k-1);
      assign ys = y_ff[k-1] >>> (k-1);
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            neg_ff[k] <= neg_ff[k-1];
            if (!z_ff[k-1][CW-1]) begin
               x_ff[k] <= x_ff[k-1] - ys;
               y_ff[k] <= y_ff[k-1] + xs;
               z_ff[k] <= z_ff[k-1] - e2q_pkg::ATAN_Q30[k-1];
            end else begin
               x_ff[k] <= x_ff[k-1] + ys;
               y_ff[k] <= y_ff[k-1] - xs;
               z_ff[k] <= z_ff[k-1] + e2q_pkg::ATAN_Q30[k-1];
            end
         end
      end
   end

   assign cos_q30 = neg_ff[NRUN] ? -x_ff[NRUN][31:0] : x_ff[NRUN][31:0];
   assign sin_q30 = y_ff[NRUN][31:0];
endmodule

### src/euler_to_quaternion_core.sv
`timescale 1ns / 1ps
// Pipeline: angle fold, one CORDIC rotation per stage, two product stages and a
// round/saturate stage.
// Throughput: one item per cycle; each stage holds only while its successor is full.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
module euler_to_quaternion_core #(
   parameter int ANGLE_BITS     = e2q_pkg::ANGLE_BITS,
   parameter int COMPONENT_BITS = e2q_pkg::COMPONENT_BITS,
   parameter int CORDIC_STAGES  = e2q_pkg::CORDIC_STAGES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [ANGLE_BITS-1:0]     req_yaw_angle,
   input  logic signed [ANGLE_BITS-1:0]     req_pitch_angle,
   input  logic signed [ANGLE_BITS-1:0]     req_roll_angle,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [COMPONENT_BITS-1:0] rsp_quat_x,
   output logic signed [COMPONENT_BITS-1:0] rsp_quat_y,
   output logic signed [COMPONENT_BITS-1:0] rsp_quat_z,
   output logic signed [COMPONENT_BITS-1:0] rsp_quat_w
);
   localparam int NRUN = e2q_pkg::run_stages(CORDIC_STAGES);
   localparam int T    = NRUN + 4;
   localparam int SH2  = 32 - COMPONENT_BITS;
   localparam logic signed [33:0] RND  = (SH2 > 0) ? (34'sd1 <<< (SH2 - 1)) : 34'sd0;
   localparam logic signed [33:0] MAXV = (34'sd1 <<< (COMPONENT_BITS - 1)) - 34'sd1;
   localparam logic signed [33:0] MINV = -MAXV - 34'sd1;

   logic [T-1:0] vld_ff;
   logic [T-1:0] vld_in;
   logic [T-1:0] en;

   for (genvar k = 0; k < T; k++) begin : g_ctl
      if (k == T - 1) begin : g_last
         assign en[k] = !vld_ff[k] || rsp_ready;
      end else begin : g_mid
         assign en[k] = !vld_ff[k] || en[k+1];
      end
      if (k == 0) begin : g_first
         assign vld_in[k] = en[k] ? req_valid : vld_ff[k];
      end else begin : g_next
         assign vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[T-1];

   logic signed [31:0] cx, sx, cy, sy, cz, sz;

   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .adv(en[NRUN:0]), .angle(req_yaw_angle), .cos_q30(cx), .sin_q30(sx));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .adv(en[NRUN:0]), .angle(req_pitch_angle), .cos_q30(cy), .sin_q30(sy));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .adv(en[NRUN:0]), .angle(req_roll_angle), .cos_q30(cz), .sin_q30(sz));

   logic signed [31:0] p_ss_ff, p_cc_ff, p_sc_ff, p_cs_ff, cy_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (en[NRUN+1]) begin
         p_ss_ff <= e2q_pkg::mul_q30(sx, sz);
         p_cc_ff <= e2q_pkg::mul_q30(cx, cz);
         p_sc_ff <= e2q_pkg::mul_q30(sx, cz);
         p_cs_ff <= e2q_pkg::mul_q30(cx, sz);
         cy_ff   <= cy;
         sy_ff   <= sy;
      end
   end

   logic signed [31:0] t_ff [8];

   always_ff @(posedge clock) begin
      if (en[NRUN+2]) begin
         t_ff[0] <= e2q_pkg::mul_q30(p_ss_ff, cy_ff);
         t_ff[1] <= e2q_pkg::mul_q30(p_cc_ff, sy_ff);
         t_ff[2] <= e2q_pkg::mul_q30(p_sc_ff, cy_ff);
         t_ff[3] <= e2q_pkg::mul_q30(p_cs_ff, sy_ff);
         t_ff[4] <= e2q_pkg::mul_q30(p_cs_ff, cy_ff);
         t_ff[5] <= e2q_pkg::mul_q30(p_sc_ff, sy_ff);
         t_ff[6] <= e2q_pkg::mul_q30(p_cc_ff, cy_ff);
         t_ff[7] <= e2q_pkg::mul_q30(p_ss_ff, sy_ff);
      end
   end

   function automatic logic signed [COMPONENT_BITS-1:0] to_comp(
      input logic signed [31:0] a,
      input logic signed [31:0] b,
      input logic               sub
   );
      logic signed [33:0] s;
      logic signed [33:0] r;
      s = sub ? (34'(a) - 34'(b)) : (34'(a) + 34'(b));
      r = (s + RND) >>> SH2;
      if (r > MAXV) begin
         r = MAXV;
      end else if (r < MINV) begin
         r = MINV;
      end
      return r[COMPONENT_BITS-1:0];
   endfunction

   logic signed [COMPONENT_BITS-1:0] qx_ff, qy_ff, qz_ff, qw_ff;

   always_ff @(posedge clock) begin
      if (en[NRUN+3]) begin
         qx_ff <= to_comp(t_ff[0], t_ff[1], 1'b0);
         qy_ff <= to_comp(t_ff[2], t_ff[3], 1'b0);
         qz_ff <= to_comp(t_ff[4], t_ff[5], 1'b1);
         qw_ff <= to_comp(t_ff[6], t_ff[7], 1'b1);
      end
   end

   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;
   assign rsp_quat_w = qw_ff;

`ifndef NO_ASSERTIONS
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("pipeline stalls with empty output stage");
   a_taken_out_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready) else $error("pipeline stalls while output drains");
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");
`endif
endmodule

### tb/e2q_checker.sv
`timescale 1ns / 1ps
module e2q_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_roll_angle,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic signed [15:0] rsp_quat_x,
   input  logic signed [15:0] rsp_quat_y,
   input  logic signed [15:0] rsp_quat_z,
   input  logic signed [15:0] rsp_quat_w,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
   } quat_type;

   quat_type quat_fifo[$];

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void half_angle_trig(input logic signed [15:0] ang,
                                           output longint c, output longint s);
      longint h, x, y, z, xs, ys;
      bit flip;
      h = longint'(ang) * (longint'(1) << (32 - e2q_pkg::ANGLE_BITS));
      flip = 0;
      if (h > longint'(e2q_pkg::HALF_PI_Q30)) begin
         h = longint'(e2q_pkg::PI_Q30) - h;
         flip = 1;
      end else if (h < -longint'(e2q_pkg::HALF_PI_Q30)) begin
         h = -longint'(e2q_pkg::PI_Q30) - h;
         flip = 1;
      end
      x = longint'(e2q_pkg::GAIN_Q30);
      y = 0;
      z = h;
      for (int i = 0; i < e2q_pkg::CORDIC_STAGES && i < e2q_pkg::TABLE_LEN; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(e2q_pkg::ATAN_Q30[i]);
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(e2q_pkg::ATAN_Q30[i]);
         end
      end
      c = flip ? -x : x;
      s = y;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return floor_shift(a * b + (longint'(1) << 29), 30);
   endfunction

   function automatic longint fx_mul3(longint a, longint b, longint c);
      return fx_mul(fx_mul(a, b), c);
   endfunction

   function automatic logic signed [15:0] to_q14(longint v);
      longint r, hi, lo;
      int sh;
      sh = 32 - e2q_pkg::COMPONENT_BITS;
      hi = (longint'(1) << (e2q_pkg::COMPONENT_BITS - 1)) - 1;
      lo = -hi - 1;
      r = (sh > 0) ? floor_shift(v + (longint'(1) << (sh - 1)), sh) : v;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r[15:0];
   endfunction

   function automatic quat_type euler_to_quat(logic signed [15:0] yaw,
                                               logic signed [15:0] pitch,
                                               logic signed [15:0] roll);
      longint cx, sx, cy, sy, cz, sz;
      quat_type q;
      half_angle_trig(yaw, cx, sx);
      half_angle_trig(pitch, cy, sy);
      half_angle_trig(roll, cz, sz);
      q.qx = to_q14(fx_mul3(sx, sz, cy) + fx_mul3(cx, cz, sy));
      q.qy = to_q14(fx_mul3(sx, cz, cy) + fx_mul3(cx, sz, sy));
      q.qz = to_q14(fx_mul3(cx, sz, cy) - fx_mul3(sx, cz, sy));
      q.qw = to_q14(fx_mul3(cx, cz, cy) - fx_mul3(sx, sz, sy));
      return q;
   endfunction

   assign pending = quat_fifo.size();

   always @(posedge clock) begin
      quat_type exp_q;
      quat_type got_q;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            quat_fifo = {quat_fifo,
                         euler_to_quat(req_yaw_angle, req_pitch_angle, req_roll_angle)};
         if (rsp_valid && rsp_ready) begin
            got_q = '{rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w};
            if (quat_fifo.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected item: x=%0d y=%0d z=%0d w=%0d",
                           got_q.qx, got_q.qy, got_q.qz, got_q.qw);
               fail_count <= fail_count + 1;
            end else begin
               exp_q = quat_fifo.pop_front();
               if (exp_q != got_q) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp x=%0d y=%0d z=%0d w=%0d",
                               " got x=%0d y=%0d z=%0d w=%0d"},
                              exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw,
                              got_q.qx, got_q.qy, got_q.qz, got_q.qw);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/tb_euler_to_quaternion_core.sv
`timescale 1ns / 1ps
module tb_euler_to_quaternion_core;
   localparam int LATENCY     = e2q_pkg::CORDIC_STAGES + 4;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_yaw_angle = 0;
   logic signed [15:0] req_pitch_angle = 0;
   logic signed [15:0] req_roll_angle = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   bit   stall_enable = 1;

   always #5 clock = ~clock;

   euler_to_quaternion_core u_top (.*);

   e2q_checker u_checker (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(0, 15) - 8);
         3: return 16'(16'sh3244 + $urandom_range(0, 8) - 4);
         4: return 16'(-16'sh3244 + $urandom_range(0, 8) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : rsp_side
      int g;
      @(posedge clock);
      forever begin
         g = stall_enable ? gap_len() : 0;
         if (g > 0) begin
            rsp_ready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
      req_valid <= 1;
      req_yaw_angle <= yaw;
      req_pitch_angle <= pitch;
      req_roll_angle <= roll;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin : req_side
      logic [15:0] corner [6];
      int g;
      corner = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h3244};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 6; i++)
         send_angles(corner[3'(i)], corner[3'((i + 2) % 6)], corner[3'((i + 4) % 6)]);
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'h7fff, 16'h7fff, 16'h7fff);
      send_angles(16'h5555, 16'haaaa, 16'hcccc);
      send_angles(16'haaaa, 16'h5555, 16'h3333);
      send_angles(16'hcdbc, 16'h3244, 16'h1922);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      for (int n = 0; n < 2000; n++) begin
         if (n == 600) stall_enable = 0;
         if (n == 1000) begin
            stall_enable = 1;
            req_valid <= 0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         g = (n >= 600 && n < 1000) ? 0 : gap_len();
         if (g > 0) begin
            req_valid <= 0;
            repeat (g) @(posedge clock);
         end
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
